>>> rtl/core/buffer_pool_pin_manager_core_macros.svh
// Assertion macros used by the pin manager top level.
`ifndef BUFFER_POOL_PIN_MANAGER_CORE_MACROS_SVH
`define BUFFER_POOL_PIN_MANAGER_CORE_MACROS_SVH

// same-cycle implication
`define BPPM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bppm_pkg.sv
// Types and constants of the buffer pool pin manager.
package bppm_pkg;

  localparam int MAX_OUT  = 8;
  localparam int FLUSH_CW = $clog2(MAX_OUT);

  typedef enum logic [1:0] {
    CMD_PIN   = 2'd0,
    CMD_UNPIN = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_MARK  = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_FRAME  = 2'd1,
    STS_UNPIN_BAD = 2'd2,
    STS_PIN_FULL  = 2'd3
  } sts_e_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_FLUSH = 1'b1
  } bk_state_t;

  typedef struct packed {
    cmd_e_t      cmd;
    logic [31:0] block_id;
    logic [2:0]  frame_index;
    logic [15:0] txn;
    logic        in_pool;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } head_t;

  typedef struct packed {
    sts_e_t      status;
    logic [2:0]  frame;
    logic        hit;
    logic        needs_load;
    logic        writeback_valid;
    logic [31:0] writeback_block;
    logic [3:0]  available;
    logic        last;
  } res_t;

endpackage

>>> rtl/core/bppm_ifs.sv
// Command and result channel interfaces.
interface bppm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] block_id;
  logic [2:0]  frame_index;
  logic [15:0] txn;

  modport source (output valid, cmd, block_id, frame_index, txn, input ready);
  modport sink   (input valid, cmd, block_id, frame_index, txn, output ready);
endinterface

interface bppm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  frame;
  logic        hit;
  logic        needs_load;
  logic        writeback_valid;
  logic [31:0] writeback_block;
  logic [3:0]  available;
  logic        last;

  modport source (output valid, status, frame, hit, needs_load, writeback_valid,
                  writeback_block, available, last, input ready);
  modport sink   (input valid, status, frame, hit, needs_load, writeback_valid,
                  writeback_block, available, last, output ready);
endinterface

>>> rtl/core/buffer_pool_pin_manager_core.sv
// Top level of the buffer pool pin manager.
//
//  channel  dir  payload                                          beat on
//  in_ch    in   cmd, block_id, frame_index, txn                  valid & ready
//  out_ch   out  status, frame, hit, needs_load, writeback_*,     valid & ready
//                available, last
//
// Pin, unpin and mark: the result register loads as the command leaves the queue head.
// Flush: captures the match mask, then one beat per cycle while out_ch is not stalled, up to 8.
// A two-entry command queue lets commands arrive while the back end is busy.
// Reset (sync) clears pin counts, flags and queue, sets free count to NUM_FRAMES; tags are not cleared.
// A stalled result holds the back end; the queue keeps taking commands until full.
`include "buffer_pool_pin_manager_core_macros.svh"

module buffer_pool_pin_manager_core #(
  parameter int NUM_FRAMES = 8,
  parameter int PIN_BITS   = 8
) (
  input logic         clk,
  input logic         rst,
  bppm_in_if.sink     in_ch,
  bppm_out_if.source  out_ch
);

  bppm_pkg::head_t head;
  logic            pop;

  bppm_front #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  bppm_back #(
    .NUM_FRAMES (NUM_FRAMES),
    .PIN_BITS   (PIN_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  `BPPM_ASSERT_IMPL(a_load_on_miss, clk, rst, out_ch.valid && out_ch.needs_load, !out_ch.hit && out_ch.status == bppm_pkg::STS_OK, "load requested on hit or failed pin")
  `BPPM_ASSERT_IMPL(a_avail_bound, clk, rst, out_ch.valid, (NUM_FRAMES > 15) || (int'(out_ch.available) <= NUM_FRAMES), "available above pool size")
  `BPPM_ASSERT_NEXT(a_flush_stream, clk, rst, out_ch.valid && !out_ch.last, out_ch.valid, "gap inside a flush burst")

endmodule

>>> rtl/core/bppm_front.sv
// Front end: command decode and two-entry command queue.
module bppm_front #(
  parameter int NUM_FRAMES = 8
) (
  input  logic              clk,
  input  logic              rst,
  bppm_in_if.sink           in_ch,
  input  logic              pop,
  output bppm_pkg::head_t   head
);

  bppm_pkg::op_t q [2];
  logic [1:0]    count;
  logic          wr_ptr;
  logic          rd_ptr;
  logic          push;
  bppm_pkg::op_t op_in;

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    op_in.cmd         = bppm_pkg::cmd_e_t'(in_ch.cmd);
    op_in.block_id    = in_ch.block_id;
    op_in.frame_index = in_ch.frame_index;
    op_in.txn         = in_ch.txn;
    op_in.in_pool     = (int'(in_ch.frame_index) < NUM_FRAMES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= op_in;
  end

  assign head.valid = (count != 2'd0);
  assign head.op    = q[rd_ptr];

endmodule

>>> rtl/core/bppm_back.sv
// Back end: frame table, pin/unpin/mark execution, flush walk, result register.
module bppm_back #(
  parameter int NUM_FRAMES = 8,
  parameter int PIN_BITS   = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  bppm_pkg::head_t  head,
  output logic             pop,
  bppm_out_if.source       out_ch
);

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  logic [31:0]         tag      [NUM_FRAMES];
  logic [15:0]         mtxn     [NUM_FRAMES];
  logic [PIN_BITS-1:0] pin_cnt  [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] assigned;
  logic [NUM_FRAMES-1:0] modified;
  logic [CW-1:0]       free_count, free_next;
  bppm_pkg::bk_state_t state, state_next;
  logic [NUM_FRAMES-1:0] fmask;
  logic [bppm_pkg::FLUSH_CW-1:0] fcnt;

  logic          ovalid;
  bppm_pkg::res_t ores, res;

  logic [NUM_FRAMES-1:0] hit_vec, free_vec, match_vec, fl_rest;
  logic          hit_any, free_any;
  logic [FW-1:0] hit_idx, vic_idx, fl_idx, fidx;
  logic          out_free, load;
  logic          pin_inc, pin_miss, unpin, mark, fl_start, fl_emit;

  assign out_free = !ovalid || out_ch.ready;
  assign fidx     = FW'(head.op.frame_index);
  assign fl_rest  = fmask & (fmask - NUM_FRAMES'(1));

  // parallel tag match and lowest-index picks
  always_comb begin
    hit_idx = '0;
    vic_idx = '0;
    fl_idx  = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      hit_vec[i]   = assigned[i] && (tag[i] == head.op.block_id);
      free_vec[i]  = (pin_cnt[i] == '0);
      match_vec[i] = modified[i] && (mtxn[i] == head.op.txn);
    end
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_idx = FW'(i);
      if (free_vec[i]) vic_idx = FW'(i);
      if (fmask[i])    fl_idx  = FW'(i);
    end
    hit_any  = |hit_vec;
    free_any = |free_vec;
  end

  always_comb begin
    state_next = state;
    free_next  = free_count;
    pop        = 1'b0;
    load       = 1'b0;
    pin_inc    = 1'b0;
    pin_miss   = 1'b0;
    unpin      = 1'b0;
    mark       = 1'b0;
    fl_start   = 1'b0;
    fl_emit    = 1'b0;
    res        = '0;
    res.status = bppm_pkg::STS_OK;
    case (state)
      bppm_pkg::BK_IDLE: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          case (head.op.cmd)
            bppm_pkg::CMD_PIN: begin
              load     = 1'b1;
              res.last = 1'b1;
              if (hit_any) begin
                res.hit   = 1'b1;
                res.frame = 3'(hit_idx);
                if (pin_cnt[hit_idx] == PIN_MAX) begin
                  res.status = bppm_pkg::STS_PIN_FULL;
                end else begin
                  pin_inc = 1'b1;
                  if (pin_cnt[hit_idx] == '0 && free_count != '0)
                    free_next = free_count - CW'(1);
                end
              end else if (free_any) begin
                pin_miss            = 1'b1;
                res.frame           = 3'(vic_idx);
                res.needs_load      = 1'b1;
                res.writeback_valid = assigned[vic_idx] && modified[vic_idx];
                res.writeback_block = res.writeback_valid ? tag[vic_idx] : 32'd0;
                if (free_count != '0) free_next = free_count - CW'(1);
              end else begin
                res.status = bppm_pkg::STS_NO_FRAME;
              end
            end
            bppm_pkg::CMD_UNPIN: begin
              load      = 1'b1;
              res.last  = 1'b1;
              res.frame = head.op.frame_index;
              if (!head.op.in_pool || pin_cnt[fidx] == '0) begin
                res.status = bppm_pkg::STS_UNPIN_BAD;
              end else begin
                unpin = 1'b1;
                if (pin_cnt[fidx] == PIN_BITS'(1) && int'(free_count) < NUM_FRAMES)
                  free_next = free_count + CW'(1);
              end
            end
            bppm_pkg::CMD_FLUSH: begin
              fl_start   = 1'b1;
              state_next = bppm_pkg::BK_FLUSH;
            end
            bppm_pkg::CMD_MARK: begin
              load      = 1'b1;
              res.last  = 1'b1;
              res.frame = head.op.frame_index;
              mark      = head.op.in_pool && assigned[fidx];
            end
            default: ;
          endcase
        end
      end
      bppm_pkg::BK_FLUSH: begin
        if (out_free) begin
          load = 1'b1;
          if (fmask == '0) begin
            res.last   = 1'b1;
            state_next = bppm_pkg::BK_IDLE;
          end else begin
            fl_emit             = 1'b1;
            res.frame           = 3'(fl_idx);
            res.writeback_valid = 1'b1;
            res.writeback_block = tag[fl_idx];
            // capped at MAX_OUT beats; leftovers stay marked
            if (fl_rest == '0 || fcnt == bppm_pkg::FLUSH_CW'(bppm_pkg::MAX_OUT - 1)) begin
              res.last   = 1'b1;
              state_next = bppm_pkg::BK_IDLE;
            end
          end
        end
      end
      default: state_next = bppm_pkg::BK_IDLE;
    endcase
    res.available = 4'(free_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bppm_pkg::BK_IDLE;
      free_count <= CW'(NUM_FRAMES);
      assigned   <= '0;
      modified   <= '0;
      fmask      <= '0;
      fcnt       <= '0;
      ovalid     <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) pin_cnt[i] <= '0;
    end else begin
      state      <= state_next;
      free_count <= free_next;
      if (load)              ovalid <= 1'b1;
      else if (out_ch.ready) ovalid <= 1'b0;
      if (pin_inc) pin_cnt[hit_idx] <= pin_cnt[hit_idx] + PIN_BITS'(1);
      if (pin_miss) begin
        modified[vic_idx] <= 1'b0;
        assigned[vic_idx] <= 1'b1;
        pin_cnt[vic_idx]  <= PIN_BITS'(1);
      end
      if (unpin) pin_cnt[fidx] <= pin_cnt[fidx] - PIN_BITS'(1);
      if (mark)  modified[fidx] <= 1'b1;
      if (fl_start) begin
        fmask <= match_vec;
        fcnt  <= '0;
      end
      if (fl_emit) begin
        modified[fl_idx] <= 1'b0;
        fmask            <= fl_rest;
        fcnt             <= fcnt + bppm_pkg::FLUSH_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pin_miss) tag[vic_idx] <= head.op.block_id;
    if (mark)     mtxn[fidx]   <= head.op.txn;
    if (load)     ores         <= res;
  end

  assign out_ch.valid           = ovalid;
  assign out_ch.status          = ores.status;
  assign out_ch.frame           = ores.frame;
  assign out_ch.hit             = ores.hit;
  assign out_ch.needs_load      = ores.needs_load;
  assign out_ch.writeback_valid = ores.writeback_valid;
  assign out_ch.writeback_block = ores.writeback_block;
  assign out_ch.available       = ores.available;
  assign out_ch.last            = ores.last;

endmodule
